/* design/scrollback_text_console_assert.svh */
// -----------------------------------------------------------------------------
// Scrollback text console assertion macros
// Concurrent checks on the console clock, masked while reset is high.
// -----------------------------------------------------------------------------
`ifndef SCROLLBACK_TEXT_CONSOLE_ASSERT_SVH
`define SCROLLBACK_TEXT_CONSOLE_ASSERT_SVH

// Check a condition at every clock edge.
`define STC_ASSERT_INV(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check a condition in the cycle after a trigger.
`define STC_ASSERT_NEXT(label, trig, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (expr)) \
      else $error(msg);

`endif

/* design/stc_pkg.sv */
// -----------------------------------------------------------------------------
// Scrollback text console package
// Field widths, operation codes and the cell format shared by the console.
// -----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

   localparam int OP_W     = 3;
   localparam int BYTE_W   = 8;
   localparam int ROWSEL_W = 5;
   localparam int COLSEL_W = 7;
   localparam int COUNT_W  = 32;

   localparam logic [OP_W-1:0] OP_PUT_CHAR    = 3'd0;
   localparam logic [OP_W-1:0] OP_NEW_LINE    = 3'd1;
   localparam logic [OP_W-1:0] OP_SCROLL_UP   = 3'd2;
   localparam logic [OP_W-1:0] OP_SCROLL_DOWN = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_CELL   = 3'd4;

   localparam logic [BYTE_W-1:0] BLANK_CHAR  = 8'h20;
   localparam logic [BYTE_W-1:0] BLANK_COLOR = 8'h0F;

   typedef struct packed {
      logic [BYTE_W-1:0] color;
      logic [BYTE_W-1:0] code;
   } cell_type;

   localparam cell_type BLANK_CELL = '{color: BLANK_COLOR, code: BLANK_CHAR};

endpackage

`default_nettype wire

/* design/stc_if.sv */
// -----------------------------------------------------------------------------
// Scrollback text console channels
// Request and response item channels with valid/ready handshake.
// -----------------------------------------------------------------------------
`default_nettype none

interface stc_req_if
   import stc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [BYTE_W-1:0]   char_code;
   logic [BYTE_W-1:0]   char_color;
   logic [ROWSEL_W-1:0] view_row;
   logic [COLSEL_W-1:0] view_column;

   modport source (
      output valid, operation, char_code, char_color, view_row, view_column,
      input  ready
   );
   modport sink (
      input  valid, operation, char_code, char_color, view_row, view_column,
      output ready
   );
endinterface

interface stc_rsp_if
   import stc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  cell_char;
   logic [BYTE_W-1:0]  cell_color;
   logic               cell_present;
   logic [COUNT_W-1:0] first_visible_line;
   logic [COUNT_W-1:0] line_count;

   modport source (
      output valid, cell_char, cell_color, cell_present, first_visible_line, line_count,
      input  ready
   );
   modport sink (
      input  valid, cell_char, cell_color, cell_present, first_visible_line, line_count,
      output ready
   );
endinterface

`default_nettype wire

/* design/scrollback_text_console.sv */
// -----------------------------------------------------------------------------
// Scrollback text console
// The console keeps HISTORY_LINES lines of COLUMNS cells in a ring memory with
// one full text line per word, plus a view of VIEW_ROWS lines onto it. Every
// request item yields one response item. In the accept cycle the ring row an
// item touches is read into a register; in the write-back state the row is
// modified and written back (a new line writes a blank row in one write) and
// the response is loaded into the output register. A new item is not taken
// until the write-back of the previous one is done.
// A new item is taken while the previous response still waits; the write-back
// cycle holds only if that response has not been taken yet. After reset the
// console zeroes ring row 0, the only row readable before its first write;
// request ready stays low while it does so.
// -----------------------------------------------------------------------------
`default_nettype none

`include "scrollback_text_console_assert.svh"

module scrollback_text_console
   import stc_pkg::*;
#(
   parameter int COLUMNS       = 80,
   parameter int VIEW_ROWS     = 18,
   parameter int HISTORY_LINES = 512
) (
   input  logic      clock,
   input  logic      reset,
   stc_req_if.sink   req_chan,
   stc_rsp_if.source rsp_chan
);

   // Widths and constants derived from the geometry
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int CURSOR_W = $clog2(COLUMNS + 1);
   localparam int ROW_W    = $clog2(HISTORY_LINES);
   localparam int VR_MOD   = VIEW_ROWS % HISTORY_LINES;

   localparam logic [CURSOR_W-1:0] COLS_C     = CURSOR_W'(COLUMNS);
   localparam logic [ROW_W-1:0]    LAST_ROW_C = ROW_W'(HISTORY_LINES - 1);
   localparam logic [ROW_W:0]      H_X        = (ROW_W + 1)'(HISTORY_LINES);
   localparam logic [ROW_W:0]      ROW_BACK_X = (ROW_W + 1)'(HISTORY_LINES - VR_MOD);
   localparam logic [COUNT_W-1:0]  H_32       = COUNT_W'(HISTORY_LINES);
   localparam logic [COUNT_W-1:0]  VR_32      = COUNT_W'(VIEW_ROWS);
   localparam logic [COUNT_W-1:0]  COLS_32    = COUNT_W'(COLUMNS);

   // Sequencer codes
   localparam logic [1:0] ST_INIT = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   typedef cell_type [COLUMNS-1:0] row_type;

   // Ring memory: one text line per word
   row_type ring_mem [HISTORY_LINES];

   logic [1:0]          state_ff,   state_in;
   logic [CURSOR_W-1:0] col_ff,     col_in;      // cursor column, may equal COLUMNS
   logic [COUNT_W-1:0]  lw_ff,      lw_in;       // lines written, cursor line + 1
   logic [COUNT_W-1:0]  vt_ff,      vt_in;       // logical line at top of view
   logic [ROW_W-1:0]    cur_row_ff, cur_row_in;  // cursor line modulo history depth
   logic [ROW_W-1:0]    vt_row_ff,  vt_row_in;   // view top modulo history depth
   logic                rsp_valid_ff, rsp_valid_in;

   // Held item
   logic [OP_W-1:0]     op_ff;
   logic [BYTE_W-1:0]   code_ff;
   logic [BYTE_W-1:0]   color_ff;
   logic [ROWSEL_W-1:0] vrow_ff;
   logic [COLSEL_W-1:0] vcol_ff;

   // Response register
   logic [BYTE_W-1:0]   cell_char_ff;
   logic [BYTE_W-1:0]   cell_color_ff;
   logic                cell_present_ff;
   logic [COUNT_W-1:0]  first_line_ff;
   logic [COUNT_W-1:0]  line_count_ff;

   // Memory ports
   row_type             rd_row_ff;
   logic                mem_we;
   logic [ROW_W-1:0]    mem_waddr;
   row_type             mem_wdata;
   logic [ROW_W-1:0]    mem_raddr;
   logic [ROW_W:0]      rd_sum;

   // Handshake
   logic req_accept;
   logic slot_free;
   logic exec_go;

   // Execute datapath
   logic                is_put, is_nl, wrap_put, advance;
   logic [ROW_W-1:0]    row_inc, adv_row, row_next, lw_row_next, fb_row;
   logic [ROW_W:0]      fb_sum;
   logic [COUNT_W-1:0]  lw_next, fb_top, lowest, highest;
   logic [CURSOR_W-1:0] col_next;
   logic                up_ok, dn_ok;
   logic [COUNT_W-1:0]  vt_next;
   logic [ROW_W-1:0]    vt_row_next;
   logic [COUNT_W-1:0]  read_line;
   logic                read_hit;
   cell_type            rd_cell;
   cell_type            put_cell;
   row_type             blank_row;

   // ---------------------------------------------------------------------
   // Handshake: take an item only when idle; write back once the response
   // register is free or being drained.
   // ---------------------------------------------------------------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && (state_ff == ST_IDLE);
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign exec_go        = (state_ff == ST_EXEC) && slot_free;

   // Row to read at accept: the view row for a cell read, else the cursor row
   assign rd_sum = {1'b0, vt_row_ff} + (ROW_W + 1)'(req_chan.view_row);
   always_comb begin
      if (req_chan.operation == OP_READ_CELL) begin
         mem_raddr = (rd_sum >= H_X) ? ROW_W'(rd_sum - H_X) : rd_sum[ROW_W-1:0];
      end else begin
         mem_raddr = cur_row_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Cursor and line bookkeeping for the held item
   // ---------------------------------------------------------------------
   assign is_put   = (op_ff == OP_PUT_CHAR);
   assign is_nl    = (op_ff == OP_NEW_LINE);
   assign wrap_put = is_put && (col_ff >= COLS_C);
   assign advance  = is_nl || wrap_put;

   // Next cursor row; after the line counter wraps the cursor restarts at row 0
   assign row_inc  = (cur_row_ff == LAST_ROW_C) ? '0 : cur_row_ff + 1'b1;
   assign adv_row  = (lw_ff == '0) ? '0 : row_inc;
   assign row_next = advance ? adv_row : cur_row_ff;
   assign lw_next  = advance ? lw_ff + 1'b1 : lw_ff;

   always_comb begin
      if (is_nl) begin
         col_next = '0;
      end else if (wrap_put) begin
         col_next = CURSOR_W'(1);
      end else if (is_put) begin
         col_next = col_ff + 1'b1;
      end else begin
         col_next = col_ff;
      end
   end

   // Follow the bottom: top = lines written - VIEW_ROWS, row kept modulo depth
   assign lw_row_next = (row_next == LAST_ROW_C) ? '0 : row_next + 1'b1;
   assign fb_sum      = {1'b0, lw_row_next} + ROW_BACK_X;
   always_comb begin
      if (lw_next > VR_32) begin
         fb_top = lw_next - VR_32;
         fb_row = (fb_sum >= H_X) ? ROW_W'(fb_sum - H_X) : fb_sum[ROW_W-1:0];
      end else begin
         fb_top = '0;
         fb_row = '0;
      end
   end

   // Scroll limits: oldest held line and bottom of the view
   assign lowest  = (lw_ff > H_32)  ? lw_ff - H_32  : '0;
   assign highest = (lw_ff > VR_32) ? lw_ff - VR_32 : '0;
   assign up_ok   = vt_ff > lowest;
   assign dn_ok   = vt_ff < highest;

   always_comb begin
      vt_next     = vt_ff;
      vt_row_next = vt_row_ff;
      if (is_put || is_nl) begin
         vt_next     = fb_top;
         vt_row_next = fb_row;
      end else if ((op_ff == OP_SCROLL_UP) && up_ok) begin
         vt_next     = vt_ff - 1'b1;
         vt_row_next = (vt_row_ff == '0) ? LAST_ROW_C : vt_row_ff - 1'b1;
      end else if ((op_ff == OP_SCROLL_DOWN) && dn_ok) begin
         vt_next     = vt_ff + 1'b1;
         vt_row_next = (vt_row_ff == LAST_ROW_C) ? '0 : vt_row_ff + 1'b1;
      end
   end

   // Cell read: in range of the view and still held in history
   assign read_line = vt_ff + COUNT_W'(vrow_ff);
   assign read_hit  = (op_ff == OP_READ_CELL)
                      && (COUNT_W'(vrow_ff) < VR_32)
                      && (COUNT_W'(vcol_ff) < COLS_32)
                      && (read_line < lw_ff)
                      && ((lw_ff <= H_32) || (read_line >= lw_ff - H_32));
   assign rd_cell   = rd_row_ff[vcol_ff[COL_W-1:0]];

   assign put_cell  = '{color: color_ff, code: code_ff};
   assign blank_row = {COLUMNS{BLANK_CELL}};

   // ---------------------------------------------------------------------
   // Sequencer and write-back
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      lw_in        = lw_ff;
      vt_in        = vt_ff;
      cur_row_in   = cur_row_ff;
      vt_row_in    = vt_row_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_row_ff;
      mem_wdata    = rd_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         ST_INIT: begin
            // zero row 0, the line shown from reset
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '0;
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               if (advance) begin
                  // the new line lands on a blank row
                  mem_we    = 1'b1;
                  mem_waddr = adv_row;
                  mem_wdata = blank_row;
                  if (wrap_put) begin
                     mem_wdata[0] = put_cell;
                  end
               end else if (is_put) begin
                  mem_we    = 1'b1;
                  mem_waddr = cur_row_ff;
                  mem_wdata[col_ff[COL_W-1:0]] = put_cell;
               end
               col_in       = col_next;
               lw_in        = lw_next;
               cur_row_in   = row_next;
               vt_in        = vt_next;
               vt_row_in    = vt_row_next;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= '0;
         lw_ff        <= COUNT_W'(1);
         vt_ff        <= '0;
         cur_row_ff   <= '0;
         vt_row_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         lw_ff        <= lw_in;
         vt_ff        <= vt_in;
         cur_row_ff   <= cur_row_in;
         vt_row_ff    <= vt_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the accepted item for the write-back cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_chan.operation;
         code_ff  <= req_chan.char_code;
         color_ff <= req_chan.char_color;
         vrow_ff  <= req_chan.view_row;
         vcol_ff  <= req_chan.view_column;
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (exec_go) begin
         cell_char_ff    <= read_hit ? rd_cell.code  : BLANK_CHAR;
         cell_color_ff   <= read_hit ? rd_cell.color : BLANK_COLOR;
         cell_present_ff <= read_hit;
         first_line_ff   <= vt_next;
         line_count_ff   <= lw_next;
      end
   end

   // Ring memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_row_ff <= ring_mem[mem_raddr];
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.cell_char          = cell_char_ff;
   assign rsp_chan.cell_color         = cell_color_ff;
   assign rsp_chan.cell_present       = cell_present_ff;
   assign rsp_chan.first_visible_line = first_line_ff;
   assign rsp_chan.line_count         = line_count_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `STC_ASSERT_NEXT(a_accept_to_exec, req_accept, state_ff == ST_EXEC, "accepted item not executed")
   `STC_ASSERT_INV(a_cursor_bound, col_ff <= COLS_C, "cursor column past line end")
   `STC_ASSERT_INV(a_view_in_count, vt_ff <= lw_ff, "view top beyond lines written")
   `STC_ASSERT_INV(a_row_bound, (cur_row_ff <= LAST_ROW_C) && (vt_row_ff <= LAST_ROW_C), "ring row out of range")

endmodule

`default_nettype wire
